// ----- design/png_unf_pkg.sv -----
// Package for the PNG scanline unfilter unit: sizes, filter type codes,
// the stage record passed from the sequencer to the reconstruction stage.
// No dependencies.
package png_unf_pkg;

    localparam int MAX_ROW_PIXELS  = 4096;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int STORE_DEPTH     = MAX_ROW_PIXELS * BYTES_PER_PIXEL;

    localparam int PIX_W  = 13;
    localparam int BYTE_W = 8;
    localparam int POS_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
    localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
    localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

    typedef struct packed {
        logic              is_filter;
        logic [BYTE_W-1:0] raw;
        logic [BYTE_W-1:0] filter;
        logic              first_row;
        logic              eor;
        logic [ADDR_W-1:0] idx;
    } t_stage;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    // Bytes in a row, with the pixel count held to its legal range.
    function automatic logic [POS_W-1:0] row_length(input logic [PIX_W-1:0] px);
        logic [POS_W-1:0] c;
        c = POS_W'(px);
        if (px == '0) begin
            c = POS_W'(1);
        end else if (int'(px) > MAX_ROW_PIXELS) begin
            c = POS_W'(MAX_ROW_PIXELS);
        end
        return POS_W'(c * POS_W'(BYTES_PER_PIXEL));
    endfunction

endpackage

// ----- design/png_unf_if.sv -----
// Channel interfaces of the PNG scanline unfilter unit: input bytes,
// reconstructed bytes and the row width configuration write.
// Depends on png_unf_pkg.
interface png_unf_in_if;
    logic                          valid;
    logic                          ready;
    logic [png_unf_pkg::BYTE_W-1:0] in_byte;
    logic                          new_image;
    modport source (output valid, output in_byte, output new_image, input ready);
    modport sink   (input valid, input in_byte, input new_image, output ready);
endinterface

interface png_unf_out_if;
    logic                          valid;
    logic                          ready;
    logic [png_unf_pkg::BYTE_W-1:0] pixel_byte;
    logic                          bad_filter;
    logic                          end_of_row;
    modport source (output valid, output pixel_byte, output bad_filter,
                    output end_of_row, input ready);
    modport sink   (input valid, input pixel_byte, input bad_filter,
                    input end_of_row, output ready);
endinterface

interface png_unf_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [png_unf_pkg::PIX_W-1:0] row_pixels;
    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

// ----- design/png_unf_line_store.sv -----
// Prior row store: single write port, one registered read port, and a fill
// count so that entries never written since reset read as zero.
// Depends on png_unf_pkg.
module png_unf_line_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [png_unf_pkg::ADDR_W-1:0] i_rd_addr,
    input  png_unf_pkg::t_wr_req           i_wr,
    output logic [png_unf_pkg::BYTE_W-1:0] o_rd_data
);
    import png_unf_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic [POS_W-1:0]  r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Every row writes its bytes from index zero upwards, so the written
    // entries always form one run starting at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en && (POS_W'(i_wr.addr) >= r_fill)) begin
                r_fill <= POS_W'(i_wr.addr) + POS_W'(1);
            end
            if (i_rd_en) begin
                r_rd_ok <= POS_W'(i_rd_addr) < r_fill;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(STORE_DEPTH))
        else $error("line store fill count beyond depth");

endmodule

// ----- design/png_unf_seq.sv -----
// Row sequencer: holds the row width register, counts byte positions,
// latches the filter type and issues the prior-row read for each byte.
// Depends on png_unf_pkg and png_unf_if.
module png_unf_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    png_unf_in_if.sink                    i_in,
    png_unf_cfg_if.sink                   i_cfg,
    input  logic                          i_adv,
    output logic                          o_stage_valid,
    output png_unf_pkg::t_stage            o_stage,
    output logic                          o_rd_en,
    output logic [png_unf_pkg::ADDR_W-1:0] o_rd_addr
);
    import png_unf_pkg::*;

    logic [PIX_W-1:0]  r_row_pixels;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] r_filter;
    logic              r_first;
    logic              n_first;
    logic              r_valid;
    t_stage            r_stage;
    t_stage            n_stage;

    logic              accept;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  row_len;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_valid || i_adv;
    assign accept      = i_in.valid && i_in.ready;
    assign row_len     = row_length(r_row_pixels);
    // A new image restarts the row on this byte, whatever came before.
    assign pos_eff     = i_in.new_image ? '0 : r_pos;

    always_comb begin
        n_stage.is_filter = (pos_eff == '0);
        n_stage.raw       = i_in.in_byte;
        n_stage.filter    = r_filter;
        n_stage.first_row = r_first;
        n_stage.idx       = ADDR_W'(pos_eff - POS_W'(1));
        n_stage.eor       = (pos_eff >= row_len);
        n_pos             = pos_eff + POS_W'(1);
        n_first           = r_first;
        if (n_stage.is_filter) begin
            n_first = i_in.new_image || r_first;
        end else if (n_stage.eor) begin
            n_pos   = '0;
            n_first = 1'b0;
        end
    end

    assign o_rd_en   = accept && !n_stage.is_filter;
    assign o_rd_addr = n_stage.idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels <= PIX_W'(1);
            r_pos        <= '0;
            r_filter     <= FILT_NONE;
            r_first      <= 1'b1;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_row_pixels <= i_cfg.row_pixels;
            end
            if (accept) begin
                r_pos   <= n_pos;
                r_first <= n_first;
                r_valid <= 1'b1;
                if (n_stage.is_filter) begin
                    r_filter <= i_in.in_byte;
                end
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_stage       = r_stage;

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !n_stage.is_filter && n_stage.eor) |=> (r_pos == '0))
        else $error("position not cleared after last byte of row");

    a_filter_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_stage.is_filter) |=> (r_pos == POS_W'(1) && r_stage.is_filter))
        else $error("filter byte did not open a row");

endmodule

// ----- design/png_unf_recon.sv -----
// Reconstruction stage: applies the row's filter to one byte from the
// neighbour registers and the prior row, and holds the result register.
// Depends on png_unf_pkg and png_unf_if.
module png_unf_recon (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_stage_valid,
    input  png_unf_pkg::t_stage            i_stage,
    input  logic [png_unf_pkg::BYTE_W-1:0] i_upper,
    output logic                          o_adv,
    output png_unf_pkg::t_wr_req           o_wr,
    png_unf_out_if.source                 o_out
);
    import png_unf_pkg::*;

    logic [BYTE_W-1:0] r_left  [BYTES_PER_PIXEL];
    logic [BYTE_W-1:0] r_upl   [BYTES_PER_PIXEL];
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_pixel;
    logic              r_bad;
    logic              r_eor;

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] add;
    logic [BYTE_W-1:0] rec;
    logic              bad;
    logic [BYTE_W:0]   avg_sum;
    logic signed [BYTE_W+1:0] pa;
    logic signed [BYTE_W+1:0] pb;
    logic signed [BYTE_W+1:0] pc;
    logic [BYTE_W-1:0] paeth;

    assign a = r_left[BYTES_PER_PIXEL-1];
    assign c = r_upl[BYTES_PER_PIXEL-1];
    assign b = i_stage.first_row ? '0 : i_upper;

    assign avg_sum = {1'b0, a} + {1'b0, b};

    // With p = a + b - c the three distances reduce to |b-c|, |a-c|, |a+b-2c|.
    always_comb begin
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    end

    always_comb begin
        bad = 1'b0;
        unique case (i_stage.filter)
            FILT_NONE:  add = '0;
            FILT_SUB:   add = a;
            FILT_UP:    add = b;
            FILT_AVG:   add = avg_sum[BYTE_W:1];
            FILT_PAETH: add = paeth;
            default: begin
                add = '0;
                bad = 1'b1;
            end
        endcase
        rec = i_stage.raw + add;
    end

    assign o_adv = i_stage_valid && (i_stage.is_filter || !r_out_valid || o_out.ready);

    assign o_wr.en   = o_adv && !i_stage.is_filter;
    assign o_wr.addr = i_stage.idx;
    assign o_wr.data = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
                r_left[k] <= '0;
                r_upl[k]  <= '0;
            end
        end else begin
            if (o_adv && i_stage.is_filter) begin
                for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
                    r_left[k] <= '0;
                    r_upl[k]  <= '0;
                end
            end else if (o_adv) begin
                r_left[0] <= rec;
                r_upl[0]  <= b;
                for (int k = 1; k < BYTES_PER_PIXEL; k++) begin
                    r_left[k] <= r_left[k-1];
                    r_upl[k]  <= r_upl[k-1];
                end
            end
            if (o_adv && !i_stage.is_filter) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && !i_stage.is_filter) begin
            r_pixel <= rec;
            r_bad   <= bad;
            r_eor   <= i_stage.eor;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_byte = r_pixel;
    assign o_out.bad_filter = r_bad;
    assign o_out.end_of_row = r_eor;

    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && !i_stage.is_filter) |=> (r_out_valid && r_pixel == $past(rec)))
        else $error("pixel byte did not reach the result register");

    a_filter_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_stage.is_filter) |=> (a == '0 && c == '0))
        else $error("neighbours not cleared at row start");

endmodule

// ----- design/png_scanline_unfilter_unit.sv -----
// Top level of the PNG scanline unfilter unit (8-bit RGB, filter types 0-4).
// Depends on png_unf_pkg, png_unf_if, png_unf_seq, png_unf_line_store, png_unf_recon.
//
//   Channel  Dir  Handshake     Carries
//   i_in     in   valid/ready   in_byte, new_image
//   o_out    out  valid/ready   pixel_byte, bad_filter, end_of_row
//   i_cfg    in   valid/ready   row_pixels (always ready)
//
// One byte is accepted per cycle while the stage can advance. A pixel byte passes
// the stage register, with the registered prior-row read, then the result register.
// Filter bytes produce no result and pass the reconstruction stage.
// Reset is synchronous; the row store needs no clearing pass, as a fill count
// marks the entries written since reset.
// A stall on o_out holds the stage register and then drops i_in.ready.
module png_scanline_unfilter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    png_unf_in_if.sink     i_in,
    png_unf_cfg_if.sink    i_cfg,
    png_unf_out_if.source  o_out
);
    import png_unf_pkg::*;

    logic              stage_valid;
    t_stage            stage;
    logic              adv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] upper;
    t_wr_req           wr;

    png_unf_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg         (i_cfg),
        .i_adv         (adv),
        .o_stage_valid (stage_valid),
        .o_stage       (stage),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    png_unf_line_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (upper)
    );

    png_unf_recon u_recon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage_valid (stage_valid),
        .i_stage       (stage),
        .i_upper       (upper),
        .o_adv         (adv),
        .o_wr          (wr),
        .o_out         (o_out)
    );

endmodule
